// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check; expects clk and arst_n in scope.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// A condition that must never be seen at a clock edge.
`define ASSERT_NEVER(label, expr, msg) \
	`ASSERT_CLK(label, !(expr), msg)

`endif

// ----- hdl/bvs_pkg.sv -----
package bvs_pkg;

	// Operation codes of an input beat.
	typedef enum logic [2:0] {
		OP_WRITE     = 3'd0,
		OP_READ      = 3'd1,
		OP_LOAD      = 3'd2,
		OP_TICK      = 3'd3,
		OP_SET_EN    = 3'd4,
		OP_SET_BLANK = 3'd5
	} bvs_op_t;

	// Resolution modes, low two bits of the resolution register.
	localparam logic [1:0] MODE_LOW  = 2'd0;
	localparam logic [1:0] MODE_MED  = 2'd1;
	localparam logic [1:0] MODE_HIGH = 2'd2;

	// Register map.
	localparam logic [5:0] RES_ADDR = 6'd32;

	// Counter constants.
	localparam logic [4:0] LPC_RESTART = 5'd4;
	localparam logic [4:0] LPC_END     = 5'd15;
	localparam logic [4:0] LPC_WRAP    = 5'd31;
	localparam logic [4:0] RPC_MAX     = 5'd31;
	localparam logic [4:0] RPC_MED_SWAP = 5'd7;
	localparam logic [2:0] LOADS_MAX   = 3'd7;
	localparam logic [2:0] LOADS_FULL  = 3'd4;
	localparam logic [1:0] PEND_MAX    = 2'd3;

	localparam int NUM_RESULTS = 4;

	// One result held in the output queue. Palette colours are looked up
	// when the result leaves the queue.
	typedef struct packed {
		logic       is_pixel;
		logic       lookup;
		logic       hi;
		logic [3:0] idx;
		logic [7:0] value;
		logic       last;
	} bvs_entry_t;

	// All results caused by one input beat.
	typedef struct packed {
		logic [2:0]                        n;
		bvs_entry_t [NUM_RESULTS-1:0]      ent;
	} bvs_batch_t;

endpackage

// ----- hdl/bvs_if.sv -----
interface bvs_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  op;
	logic [5:0]  addr;
	logic [15:0] data;

	modport source(output valid, op, addr, data, input ready);
	modport sink(input valid, op, addr, data, output ready);
endinterface

interface bvs_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic       is_pixel;
	logic       last;

	modport source(output valid, read_data, red, green, blue, is_pixel, last, input ready);
	modport sink(input valid, read_data, red, green, blue, is_pixel, last, output ready);
endinterface

// ----- hdl/bvs_core.sv -----
module bvs_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                acc,
	input  logic [2:0]          op,
	input  logic [5:0]          addr,
	input  logic [15:0]         data,
	input  logic [3:0]          lk_idx,
	output logic [15:0]         lk_word,
	output bvs_pkg::bvs_batch_t batch
);
	import bvs_pkg::*;

	logic [15:0] pal_q [16];
	logic [7:0]  res_q;
	logic [15:0] inw_q [4];
	logic [15:0] rot_q [4];
	logic [2:0]  lc_q;
	logic [4:0]  lpc_q;
	logic [4:0]  rpc_q;
	logic        cf_q;
	logic        reload_q;
	logic        de_q;
	logic        blank_q;
	logic [1:0]  pend_q;
	logic [2:0]  dly_q;

	logic [15:0] inw_d [4];
	logic [15:0] rot_d [4];
	logic [7:0]  res_d;
	logic [2:0]  lc_d;
	logic [4:0]  lpc_d;
	logic [4:0]  rpc_d;
	logic        cf_d;
	logic        reload_d;
	logic        de_d;
	logic        blank_d;
	logic [1:0]  pend_d;
	logic [2:0]  dly_d;

	// Palette port toward the output queue.
	assign lk_word = pal_q[lk_idx];

	// Colour entry, or black while blanked.
	function automatic bvs_entry_t col_entry(input logic [3:0] idx, input logic blank);
		bvs_entry_t e;
		e          = '0;
		e.is_pixel = 1'b1;
		e.lookup   = !blank;
		e.idx      = idx;
		return e;
	endfunction

	// Mono entry at a fixed level.
	function automatic bvs_entry_t mono_entry(input logic [7:0] v);
		bvs_entry_t e;
		e          = '0;
		e.is_pixel = 1'b1;
		e.value    = v;
		return e;
	endfunction

	// Next state and results for the beat at the input.
	always_comb begin
		logic [3:0]  sum;
		logic [1:0]  mode;
		logic [7:0]  mono;
		logic        restart;
		batch    = '0;
		res_d    = res_q;
		lc_d     = lc_q;
		lpc_d    = lpc_q;
		rpc_d    = rpc_q;
		cf_d     = cf_q;
		reload_d = reload_q;
		de_d     = de_q;
		blank_d  = blank_q;
		pend_d   = pend_q;
		dly_d    = dly_q;
		for (int k = 0; k < 4; k++) begin
			inw_d[k] = inw_q[k];
			rot_d[k] = rot_q[k];
		end
		sum     = {1'b0, lc_q} + {2'b00, pend_q};
		mode    = res_q[1:0];
		mono    = pal_q[0][0] ? 8'hff : 8'h00;
		restart = 1'b0;
		case (bvs_op_t'(op))
			OP_WRITE: begin
				if (addr == RES_ADDR) res_d = data[7:0];
			end
			OP_READ: begin
				batch.n            = 3'd1;
				batch.ent[0].last  = 1'b1;
				if (addr == RES_ADDR) begin
					batch.ent[0].value = res_q;
				end else if (!addr[5]) begin
					batch.ent[0].lookup = 1'b1;
					batch.ent[0].idx    = addr[4:1];
					batch.ent[0].hi     = !addr[0];
				end
			end
			OP_LOAD: begin
				if (lc_q < LOADS_FULL) inw_d[lc_q[1:0]] = data;
				if (pend_q < PEND_MAX) pend_d = pend_q + 2'd1;
				if (de_q) dly_d = dly_q | 3'b100;
			end
			OP_TICK: begin
				// Delayed load actions take effect first.
				lc_d   = (sum > {1'b0, LOADS_MAX}) ? LOADS_MAX : sum[2:0];
				pend_d = '0;
				cf_d   = cf_q | dly_q[0];
				dly_d  = dly_q >> 1;
				lpc_d  = cf_d ? lpc_q + 5'd1 : LPC_RESTART;
				// Draw pixels and shift the plane bits out.
				case (mode)
					MODE_LOW: begin
						batch.n      = 3'd2;
						batch.ent[0] = col_entry({rot_q[3][15], rot_q[2][15],
							rot_q[1][15], rot_q[0][15]}, blank_q);
						batch.ent[1] = batch.ent[0];
						for (int k = 0; k < 4; k++) rot_d[k] = rot_q[k] << 1;
					end
					MODE_MED: begin
						batch.n      = 3'd2;
						batch.ent[0] = col_entry({2'b00, rot_q[1][15], rot_q[0][15]},
							blank_q);
						batch.ent[1] = col_entry({2'b00, rot_q[1][14], rot_q[0][14]},
							blank_q);
						rot_d[0] = rot_q[0] << 2;
						rot_d[1] = rot_q[1] << 2;
					end
					MODE_HIGH: begin
						batch.n = 3'd4;
						for (int k = 0; k < 4; k++) begin
							batch.ent[k] = mono_entry(rot_q[0][15-k] ? ~mono : mono);
						end
						rot_d[0] = rot_q[0] << 4;
					end
					default: begin
						batch.n = 3'd0;
					end
				endcase
				if (reload_q) begin
					reload_d = 1'b0;
					lc_d     = '0;
				end
				// Word rotation every fourth pixel count.
				if (rpc_q[1:0] == 2'b11) begin
					if (mode == MODE_MED && rpc_q == RPC_MED_SWAP) begin
						rot_d[0] = rot_d[2];
						rot_d[1] = rot_d[3];
						rot_d[2] = '0;
						rot_d[3] = '0;
					end else if (mode == MODE_HIGH) begin
						rot_d[0] = rot_d[1];
						rot_d[1] = rot_d[2];
						rot_d[2] = rot_d[3];
						rot_d[3] = {16{pal_q[0][0]}};
					end
				end
				// End of a sixteen-pixel group.
				if (lpc_d == LPC_END) begin
					lpc_d   = LPC_WRAP;
					restart = 1'b1;
					if (lc_d == LOADS_FULL) begin
						reload_d = 1'b1;
						for (int k = 0; k < 4; k++) rot_d[k] = inw_q[k];
						if (!de_q) cf_d = 1'b0;
					end
				end
				if (restart) rpc_d = '0;
				else if (rpc_q < RPC_MAX) rpc_d = rpc_q + 5'd1;
				for (int k = 0; k < 4; k++) begin
					batch.ent[k].last = (3'(k + 1) == batch.n);
				end
			end
			OP_SET_EN: begin
				de_d = data[0];
			end
			OP_SET_BLANK: begin
				blank_d = data[0];
			end
			default: begin
			end
		endcase
	end

	// Palette byte writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 16; k++) pal_q[k] <= '0;
		end else if (acc && bvs_op_t'(op) == OP_WRITE && !addr[5]) begin
			if (addr[0]) pal_q[addr[4:1]][7:0] <= data[7:0];
			else pal_q[addr[4:1]][15:8] <= data[7:0];
		end
	end

	// Shifter state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q    <= '0;
			lc_q     <= '0;
			lpc_q    <= LPC_RESTART;
			rpc_q    <= '0;
			cf_q     <= 1'b0;
			reload_q <= 1'b0;
			de_q     <= 1'b0;
			blank_q  <= 1'b0;
			pend_q   <= '0;
			dly_q    <= '0;
			for (int k = 0; k < 4; k++) begin
				inw_q[k] <= '0;
				rot_q[k] <= '0;
			end
		end else if (acc) begin
			res_q    <= res_d;
			lc_q     <= lc_d;
			lpc_q    <= lpc_d;
			rpc_q    <= rpc_d;
			cf_q     <= cf_d;
			reload_q <= reload_d;
			de_q     <= de_d;
			blank_q  <= blank_d;
			pend_q   <= pend_d;
			dly_q    <= dly_d;
			for (int k = 0; k < 4; k++) begin
				inw_q[k] <= inw_d[k];
				rot_q[k] <= rot_d[k];
			end
		end
	end

endmodule

// ----- hdl/bvs_outq.sv -----
module bvs_outq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                acc,
	input  bvs_pkg::bvs_batch_t batch,
	output logic                can_take,
	output logic [3:0]          lk_idx,
	input  logic [15:0]         lk_word,
	bvs_out_if.source           out_ch
);
	import bvs_pkg::*;

	bvs_entry_t ent_q [NUM_RESULTS];
	logic [2:0] cnt_q;
	logic       emit;
	bvs_entry_t head;

	assign head     = ent_q[0];
	assign emit     = (cnt_q != 3'd0) && out_ch.ready;
	assign can_take = (cnt_q == 3'd0) || ((cnt_q == 3'd1) && out_ch.ready);
	assign lk_idx   = head.idx;

	// Result beat: palette colour or byte picked at the head of the queue.
	assign out_ch.valid    = (cnt_q != 3'd0);
	assign out_ch.is_pixel = head.is_pixel;
	assign out_ch.last     = head.last;
	always_comb begin
		out_ch.read_data = '0;
		out_ch.red       = '0;
		out_ch.green     = '0;
		out_ch.blue      = '0;
		if (!head.is_pixel) begin
			if (head.lookup) out_ch.read_data = head.hi ? lk_word[15:8] : lk_word[7:0];
			else out_ch.read_data = head.value;
		end else if (head.lookup) begin
			out_ch.red   = {lk_word[10:8], 5'b0};
			out_ch.green = {lk_word[6:4], 5'b0};
			out_ch.blue  = {lk_word[2:0], 5'b0};
		end else begin
			out_ch.red   = head.value;
			out_ch.green = head.value;
			out_ch.blue  = head.value;
		end
	end

	// Queue contents move one place per delivered beat.
	always_ff @(posedge clk) begin
		if (acc) begin
			for (int k = 0; k < NUM_RESULTS; k++) ent_q[k] <= batch.ent[k];
		end else if (emit) begin
			for (int k = 0; k < NUM_RESULTS - 1; k++) ent_q[k] <= ent_q[k+1];
			ent_q[NUM_RESULTS-1] <= '0;
		end
	end

	// Fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (acc) begin
			cnt_q <= batch.n;
		end else if (emit) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

endmodule

// ----- hdl/bitplane_video_shifter_top.sv -----
// Output: the first result of a beat is offered in the cycle after the beat is taken.
// Throughput: a beat is taken every cycle while the output queue is empty or its
// last result is being delivered; a beat with two or more results holds the input
// until the queue has sent all but one. A tick gives 2 results in low and medium
// resolution, 4 in high and none in mode three, one per cycle while the output is ready.
// Reset: arst_n clears palette, registers, counters and the queue at once.
module bitplane_video_shifter_top (
	input  logic      clk,
	input  logic      arst_n,
	bvs_in_if.sink    in_ch,
	bvs_out_if.source out_ch
);
	import bvs_pkg::*;

	logic       acc;
	logic       can_take;
	logic [3:0] lk_idx;
	logic [15:0] lk_word;
	bvs_batch_t batch;

	// Input beat handshake.
	assign in_ch.ready = can_take;
	assign acc         = in_ch.valid && can_take;

	bvs_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.acc    (acc),
		.op     (in_ch.op),
		.addr   (in_ch.addr),
		.data   (in_ch.data),
		.lk_idx (lk_idx),
		.lk_word(lk_word),
		.batch  (batch)
	);

	bvs_outq u_outq (
		.clk     (clk),
		.arst_n  (arst_n),
		.acc     (acc),
		.batch   (batch),
		.can_take(can_take),
		.lk_idx  (lk_idx),
		.lk_word (lk_word),
		.out_ch  (out_ch)
	);

endmodule

// ----- hdl/bvs_checker.sv -----
`include "assert_macros.svh"

module bvs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       out_is_pixel,
	input logic [7:0] out_read_data,
	input logic [7:0] out_red,
	input logic [7:0] out_green,
	input logic [7:0] out_blue
);

	// Register read beats carry no colour.
	`ASSERT_NEVER(a_read_no_colour, out_valid && !out_is_pixel && (out_red != 8'd0 || out_green != 8'd0 || out_blue != 8'd0), "read beat with colour")

	// Pixel beats carry no read byte.
	`ASSERT_NEVER(a_pixel_no_byte, out_valid && out_is_pixel && out_read_data != 8'd0, "pixel beat with read data")

	// The input only stalls while results are waiting.
	`ASSERT_CLK(a_stall_busy, !in_ready |-> out_valid, "input stalled with no result pending")

	// A stalled result beat stays offered.
	`ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid, "result beat withdrawn")

endmodule

bind bitplane_video_shifter_top bvs_checker u_bvs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (in_ch.ready),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.out_is_pixel (out_ch.is_pixel),
	.out_read_data(out_ch.read_data),
	.out_red      (out_ch.red),
	.out_green    (out_ch.green),
	.out_blue     (out_ch.blue)
);
